>>> rtl/core/wmsi_pkg.sv
// ----------------------------------------------------------------------------
// wmsi_pkg: shared types and constants for the windowed mean block
// Window size, derived widths, controller states and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package wmsi_pkg;

   // number of samples in the ring
   localparam int WINDOW     = 20;
   // sample and mean width (signed Q8.8 mm)
   localparam int SAMPLE_W   = 16;
   // ring index width
   localparam int PTR_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   // valid count width, holds 0..WINDOW
   localparam int CNT_W      = $clog2(WINDOW + 1);
   // signed running sum width, holds +/- WINDOW * 2^15
   localparam int SUM_W      = SAMPLE_W + CNT_W;
   // divider step counter width, counts SUM_W steps
   localparam int DIV_CNT_W  = $clog2(SUM_W);

   // request opcodes
   localparam logic OP_STORE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB,
      ST_ADD,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept_en;
      logic load_item;
      logic sub_old;
      logic add_new;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_fire;
      logic req_read;
      logic count_zero;
      logic div_last;
      logic out_full;
   } status_type;

endpackage

>>> rtl/core/wmsi_req_if.sv
// ----------------------------------------------------------------------------
// wmsi_req_if: request channel
// Valid/ready channel carrying one store or read request.
// ----------------------------------------------------------------------------
interface wmsi_req_if
   import wmsi_pkg::*;
   ;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic signed [SAMPLE_W-1:0] sample_value;
   logic                       sample_valid;

   modport source (output valid, op, sample_value, sample_valid, input ready);
   modport sink   (input valid, op, sample_value, sample_valid, output ready);
   modport monitor (input valid, ready, op, sample_value, sample_valid);
endinterface

>>> rtl/core/wmsi_rsp_if.sv
// ----------------------------------------------------------------------------
// wmsi_rsp_if: response channel
// Valid/ready channel carrying one window mean.
// ----------------------------------------------------------------------------
interface wmsi_rsp_if
   import wmsi_pkg::*;
   ;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] mean_value;
   logic                       mean_valid;

   modport source (output valid, mean_value, mean_valid, input ready);
   modport sink   (input valid, mean_value, mean_valid, output ready);
   modport monitor (input valid, ready, mean_value, mean_valid);
endinterface

>>> rtl/core/wmsi_ctrl.sv
// ----------------------------------------------------------------------------
// wmsi_ctrl: sequencing state machine
// Steps a store through subtract/add, and a read through the serial divide
// and the output register handoff.
// ----------------------------------------------------------------------------
module wmsi_ctrl
   import wmsi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.req_fire) begin
               if (status.req_read == OP_READ) begin
                  // empty window skips the divide
                  state_in = status.count_zero ? ST_DONE : ST_DIV_LOAD;
               end else begin
                  state_in = ST_SUB;
               end
            end
         end
         ST_SUB:      state_in = ST_ADD;
         ST_ADD:      state_in = ST_IDLE;
         ST_DIV_LOAD: state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!status.out_full) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept_en = 1'b1;
            cmd.load_item = status.req_fire;
         end
         ST_SUB:      cmd.sub_old  = 1'b1;
         ST_ADD:      cmd.add_new  = 1'b1;
         ST_DIV_LOAD: cmd.div_load = 1'b1;
         ST_DIV_RUN:  cmd.div_step = 1'b1;
         ST_DONE:     cmd.out_load = !status.out_full;
         default:     cmd = '0;
      endcase
   end

endmodule

>>> rtl/core/wmsi_dpath.sv
// ----------------------------------------------------------------------------
// wmsi_dpath: sample ring, running sum and serial divider
// Holds the ring and its running totals, divides the sum by the valid count
// one quotient bit per cycle, and drives the response register.
// ----------------------------------------------------------------------------
module wmsi_dpath
   import wmsi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   wmsi_req_if.sink          req_ch,
   wmsi_rsp_if.source        rsp_ch,
   input  cmd_type           cmd,
   output status_type        status
);

   // captured request
   logic signed [SAMPLE_W-1:0] value_ff;
   logic                       valid_ff;

   // ring and totals
   logic signed [SAMPLE_W-1:0] ring_value_ff [WINDOW];
   logic                       ring_valid_ff [WINDOW];
   logic [PTR_W-1:0]           wptr_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic [CNT_W-1:0]           total_ff;

   // divider
   logic                       neg_ff;
   logic [SUM_W-1:0]           quo_ff;
   logic [CNT_W-1:0]           rem_ff;
   logic [DIV_CNT_W-1:0]       dcnt_ff;

   // response register
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_value_ff;
   logic                       rsp_mvalid_ff;

   logic signed [SUM_W-1:0]    old_ext;
   logic signed [SUM_W-1:0]    new_ext;
   logic [PTR_W-1:0]           wptr_in;
   logic [CNT_W:0]             shifted;
   logic [CNT_W:0]             diff;
   logic                       qbit;
   logic [SUM_W-1:0]           mag;
   logic [SUM_W-1:0]           signed_quo;

   assign req_ch.ready = cmd.accept_en;

   // request capture; an invalid sample is stored as zero
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         valid_ff <= req_ch.sample_valid;
         value_ff <= req_ch.sample_valid ? req_ch.sample_value : '0;
      end
   end

   assign old_ext = {{(SUM_W-SAMPLE_W){ring_value_ff[wptr_ff][SAMPLE_W-1]}},
                     ring_value_ff[wptr_ff]};
   assign new_ext = {{(SUM_W-SAMPLE_W){value_ff[SAMPLE_W-1]}}, value_ff};
   assign wptr_in = (wptr_ff == PTR_W'(WINDOW - 1)) ? '0 : wptr_ff + 1'b1;

   // ring and totals: retire the old slot, then add the new one
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            ring_value_ff[i] <= '0;
            ring_valid_ff[i] <= 1'b1;
         end
         wptr_ff  <= '0;
         sum_ff   <= '0;
         total_ff <= CNT_W'(WINDOW);
      end else if (cmd.sub_old) begin
         if (ring_valid_ff[wptr_ff]) begin
            sum_ff   <= sum_ff - old_ext;
            total_ff <= total_ff - 1'b1;
         end
      end else if (cmd.add_new) begin
         ring_value_ff[wptr_ff] <= value_ff;
         ring_valid_ff[wptr_ff] <= valid_ff;
         if (valid_ff) begin
            sum_ff   <= sum_ff + new_ext;
            total_ff <= total_ff + 1'b1;
         end
         wptr_ff <= wptr_in;
      end
   end

   // restoring divide step on the magnitude
   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign diff    = shifted - {1'b0, total_ff};
   assign qbit    = (shifted >= {1'b0, total_ff});
   assign mag     = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         neg_ff  <= sum_ff[SUM_W-1];
         quo_ff  <= mag;
         rem_ff  <= '0;
         dcnt_ff <= DIV_CNT_W'(SUM_W - 1);
      end else if (cmd.div_step) begin
         rem_ff  <= qbit ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         quo_ff  <= {quo_ff[SUM_W-2:0], qbit};
         dcnt_ff <= dcnt_ff - 1'b1;
      end
   end

   // quotient sign restored, truncation toward zero
   assign signed_quo = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_mvalid_ff <= (total_ff != '0);
         rsp_value_ff  <= (total_ff == '0) ? '0 : signed_quo[SAMPLE_W-1:0];
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.mean_value = rsp_value_ff;
   assign rsp_ch.mean_valid = rsp_mvalid_ff;

   // status to controller
   assign status.req_fire   = req_ch.valid && cmd.accept_en;
   assign status.req_read   = req_ch.op;
   assign status.count_zero = (total_ff == '0);
   assign status.div_last   = (dcnt_ff == '0);
   assign status.out_full   = rsp_valid_ff && !rsp_ch.ready;

endmodule

>>> rtl/core/windowed_mean_skip_invalid.sv
// ----------------------------------------------------------------------------
// windowed_mean_skip_invalid: mean of a sample window, skipping no-line marks
// Ring of WINDOW signed Q8.8 positions with valid flags; a read returns the
// sum of valid samples divided by their count, truncated toward zero.
//
//   channel  dir  payload                              handshake
//   req_ch   in   op, sample_value, sample_valid       valid/ready
//   rsp_ch   out  mean_value, mean_valid               valid/ready
//
// A store goes through capture, retire old slot and write new slot.
// A read of a nonempty window runs the serial divider, which makes one
// quotient bit per cycle; a read gives one response.
// Reset leaves all slots valid at zero, so the first mean is 0, valid.
// A pending response does not block stores; a second read waits in the
// final step until the response register is taken.
// ----------------------------------------------------------------------------
module windowed_mean_skip_invalid
   import wmsi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   wmsi_req_if.sink   req_ch,
   wmsi_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   // sequencing
   wmsi_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // storage and arithmetic
   wmsi_dpath u_dpath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .status (status)
   );

endmodule

>>> rtl/core/wmsi_checker.sv
// ----------------------------------------------------------------------------
// wmsi_checker: port-level checks for the windowed mean block
// Tracks open reads and checks response ordering and content rules.
// ----------------------------------------------------------------------------
module wmsi_checker
   import wmsi_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_op,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_mean_value,
   input logic                       rsp_mean_valid
);

   logic [1:0] open_ff;
   logic [1:0] open_in;
   logic       rd_fire;
   logic       rsp_fire;

   assign rd_fire  = req_valid && req_ready && (req_op == OP_READ);
   assign rsp_fire = rsp_valid && rsp_ready;

   // reads accepted but not yet answered
   always_comb begin
      open_in = open_ff;
      if (rd_fire && !rsp_fire) begin
         open_in = open_ff + 1'b1;
      end else if (!rd_fire && rsp_fire) begin
         open_in = open_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // a response only answers an accepted read
   a_rsp_has_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (open_ff != 2'd0))
      else $error("response without an open read");

   // an empty window reports zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_mean_valid) |-> (rsp_mean_value == '0))
      else $error("invalid mean with nonzero value");

   // no response just out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_mean_value) && $stable(rsp_mean_valid)))
      else $error("stalled response changed");

endmodule

bind windowed_mean_skip_invalid wmsi_checker u_wmsi_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_op         (req_ch.op),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_mean_value (rsp_ch.mean_value),
   .rsp_mean_valid (rsp_ch.mean_valid)
);
